### rtl/swm_pkg.sv
// Shared types and constants for the sliding-window median filter.
// No dependencies; compile first.
`default_nettype none

package swm_pkg;

    localparam int SWM_WIDTH  = 16;
    localparam int SWM_WINDOW = 9;

    typedef logic signed [SWM_WIDTH-1:0] sample_t;

    // Hand-off from one cell to the next cell up the sorted chain.
    typedef struct packed {
        sample_t rm;   // entry after the leaving sample is taken out
        logic    gt;   // new sample sorts strictly below rm
    } swm_link_t;

endpackage

`default_nettype wire

### rtl/swm_if.sv
// Valid/ready channel interfaces for the median filter's input and output words.
// Depends on swm_pkg.
`default_nettype none

interface swm_in_if;
    import swm_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swm_out_if;
    import swm_pkg::*;

    logic    valid;
    logic    ready;
    sample_t median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

### rtl/sliding_window_median.sv
// Sliding-window median filter. Each accepted word carries one signed 16-bit
// sample; the block answers with one word holding the median of the last WINDOW
// samples (entry WINDOW/2 of the window in ascending order, so the upper middle
// for even windows). After reset the window holds WINDOW zeros, which count as
// samples until pushed out. The window lives in a chain of WINDOW cells,
// each holding one arrival-order slot and one sorted slot; on a sample every
// cell updates at once from its neighbours. A sample is taken every cycle as
// long as the result of the previous one is taken in the same cycle (one word
// per cycle sustained); the median appears on the output in the cycle after
// its sample is accepted and is held there until the sink takes it.
// Throughput is set by the single output register: while it holds an untaken
// word, no sample is accepted.
// Depends on swm_pkg, swm_if and swm_cell.
`default_nettype none

module sliding_window_median #(
    parameter int WINDOW = swm_pkg::SWM_WINDOW
) (
    input wire        clk,
    input wire        rst_n,
    swm_in_if.sink    in,
    swm_out_if.source out
);
    import swm_pkg::*;

    localparam int MID = WINDOW / 2;

    sample_t   hist_q [WINDOW];
    sample_t   ord_q  [WINDOW];
    swm_link_t link_q [WINDOW];
    sample_t   leaving;
    logic      in_fire;
    logic      valid_reg;
    logic      valid_next;

    // Accept when the output slot is empty or being emptied this cycle.
    assign in.ready = !valid_reg || out.ready;
    assign in_fire  = in.valid && in.ready;
    assign leaving  = hist_q[WINDOW-1];

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        sample_t   hist_in;
        sample_t   ord_hi;
        swm_link_t link_lo;

        if (i == 0)
        begin : g_lo_edge
            assign hist_in = in.sample;
            assign link_lo = '0;
        end
        else
        begin : g_lo_mid
            assign hist_in = hist_q[i-1];
            assign link_lo = link_q[i-1];
        end

        if (i == WINDOW - 1)
        begin : g_hi_edge
            assign ord_hi = ord_q[i];
        end
        else
        begin : g_hi_mid
            assign ord_hi = ord_q[i+1];
        end

        swm_cell #(
            .IS_LAST (i == WINDOW - 1)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (in_fire),
            .fresh    (in.sample),
            .leaving  (leaving),
            .hist_in  (hist_in),
            .ord_hi   (ord_hi),
            .link_lo  (link_lo),
            .link_out (link_q[i]),
            .hist_out (hist_q[i]),
            .ord_out  (ord_q[i])
        );
    end

    // Output word: set on accept, drop once taken.
    always_comb
    begin
        valid_next = valid_reg;
        if (in_fire)
            valid_next = 1'b1;
        else if (out.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // The sorted slots only move on accept, so the middle slot holds the
    // pending median for as long as the word waits.
    assign out.valid  = valid_reg;
    assign out.median = ord_q[MID];

    // ---------------------------------------------------------------- checks
    a_fire_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out.valid)
        else $error("accepted sample produced no output word");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out.valid |-> in.ready)
        else $error("input stalled with empty output slot");

    a_taken_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && out.ready && !in_fire) |=> !out.valid)
        else $error("output word repeated after being taken");

    a_median_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && !out.ready) |=> $stable(ord_q[MID]))
        else $error("pending median changed while stalled");

    for (genvar k = 0; k + 1 < WINDOW; k++)
    begin : g_chk_sorted
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            ord_q[k] <= ord_q[k+1])
            else $error("sorted chain out of order");
    end

endmodule

`default_nettype wire

### rtl/swm_cell.sv
// One cell of the median chain: one history slot and one sorted slot.
// Depends on swm_pkg.
`default_nettype none

module swm_cell #(
    parameter bit IS_LAST = 1'b0
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  en,
    input  swm_pkg::sample_t     fresh,
    input  swm_pkg::sample_t     leaving,
    input  swm_pkg::sample_t     hist_in,
    input  swm_pkg::sample_t     ord_hi,
    input  swm_pkg::swm_link_t   link_lo,
    output swm_pkg::swm_link_t   link_out,
    output swm_pkg::sample_t     hist_out,
    output swm_pkg::sample_t     ord_out
);
    import swm_pkg::*;

    sample_t hist_reg;
    sample_t hist_next;
    sample_t ord_reg;
    sample_t ord_next;
    sample_t rm;
    logic    gt;

    // The sorted slots are ascending and always hold the leaving sample, so
    // every slot at or above its first copy pulls its upper neighbour down.
    assign rm = (!IS_LAST && (ord_reg >= leaving)) ? ord_hi : ord_reg;
    // The top slot always takes the new sample if nothing below did.
    assign gt = IS_LAST ? 1'b1 : (fresh < rm);

    always_comb
    begin
        hist_next = hist_reg;
        ord_next  = ord_reg;
        if (en)
        begin
            hist_next = hist_in;
            if (link_lo.gt)
                ord_next = link_lo.rm;
            else if (gt)
                ord_next = fresh;
            else
                ord_next = rm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            ord_reg  <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
            ord_reg  <= ord_next;
        end
    end

    assign link_out.rm = rm;
    assign link_out.gt = gt;
    assign hist_out    = hist_reg;
    assign ord_out     = ord_reg;

endmodule

`default_nettype wire
